// ===== src/umdu_pkg.sv =====
`default_nettype none

package umdu_pkg;

  // Operation codes carried with each word
  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } op_t;

  // Control tag that travels down the cell chain with each word
  typedef struct packed {
    op_t  op;
    logic dbz;
  } tag_t;

endpackage

`default_nettype wire

// ===== src/unsigned_multiply_divide_unit.sv =====
`default_nettype none

// A chain of DATA_WIDTH one-bit cells, each holding one word and stepping one bit,
// feeds the output register.
// Throughput: one word per cycle unless the output stalls.
// A stalled result holds in the output register while free cells keep taking words.
// Reset (synchronous, rst_n low) clears the valid bits only; payload is not reset.
module unsigned_multiply_divide_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_req_type,
  input  wire logic [DATA_WIDTH-1:0] in_operand_a,
  input  wire logic [DATA_WIDTH-1:0] in_operand_b,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [DATA_WIDTH-1:0]      out_result_low,
  output logic [DATA_WIDTH-1:0]      out_result_high,
  output logic                       out_divide_by_zero
);

  localparam int N = DATA_WIDTH;

  logic                 vld [N+1];
  umdu_pkg::tag_t       tag [N+1];
  logic [DATA_WIDTH-1:0] hi [N+1];
  logic [DATA_WIDTH-1:0] lo [N+1];
  logic [DATA_WIDTH-1:0] m  [N+1];
  logic                 rdy [N+1];

  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_result_low_r;
  logic [DATA_WIDTH-1:0] out_result_high_r;
  logic                  out_divide_by_zero_r;
  logic                  out_rdy;

  // Load the chain head: multiply keeps multiplier in lo, divide the dividend
  assign vld[0]     = in_valid;
  assign tag[0].op  = umdu_pkg::op_t'(in_req_type);
  assign tag[0].dbz = in_req_type && (in_operand_b == '0);
  assign hi[0]      = '0;
  assign lo[0]      = in_req_type ? in_operand_a : in_operand_b;
  assign m[0]       = in_req_type ? in_operand_b : in_operand_a;
  assign in_ready   = rdy[0];

  // Chain of one-bit cells
  for (genvar k = 0; k < N; k++) begin : g_cell
    umdu_cell #(
      .W (DATA_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .prv_vld (vld[k]),
      .prv_tag (tag[k]),
      .prv_hi  (hi[k]),
      .prv_lo  (lo[k]),
      .prv_m   (m[k]),
      .rdy     (rdy[k]),
      .nxt_rdy (rdy[k+1]),
      .vld_r   (vld[k+1]),
      .tag_r   (tag[k+1]),
      .hi_r    (hi[k+1]),
      .lo_r    (lo[k+1]),
      .m_r     (m[k+1])
    );
  end

  // Output register parts the chain from the consumer
  assign out_rdy = !out_valid_r || out_ready;
  assign rdy[N]  = out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= vld[N];
    end
  end

  // Force all ones for a zero divisor
  always_ff @(posedge clk) begin
    if (out_rdy && vld[N]) begin
      out_result_low_r     <= tag[N].dbz ? '1 : lo[N];
      out_result_high_r    <= tag[N].dbz ? '1 : hi[N];
      out_divide_by_zero_r <= tag[N].dbz;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_low     = out_result_low_r;
  assign out_result_high    = out_result_high_r;
  assign out_divide_by_zero = out_divide_by_zero_r;

`ifndef ASSERT_OFF
  a_dbz_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_divide_by_zero_r |-> (&out_result_low_r) && (&out_result_high_r))
    else $error("divide by zero result not all ones");

  a_dbz_div_only: assert property (@(posedge clk) disable iff (!rst_n)
    vld[N] && tag[N].dbz |-> tag[N].op == umdu_pkg::OP_DIV)
    else $error("zero divisor flag on a multiply");

  a_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
    vld[N] && !out_rdy |=> vld[N] && $stable(lo[N]) && $stable(hi[N]))
    else $error("last cell lost its word while output stalled");
`endif

endmodule

`default_nettype wire

// ===== src/umdu_cell.sv =====
`default_nettype none

// One bit step of shift-add multiply or restoring divide.
// Multiply: hi/lo hold the partial product, lo starts as the multiplier,
//   m is the multiplicand.
// Divide: hi is the partial remainder, lo starts as the dividend and fills
//   with quotient bits from the bottom, m is the divisor.
module umdu_cell #(
  parameter int W = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            prv_vld,
  input  wire umdu_pkg::tag_t  prv_tag,
  input  wire logic [W-1:0]    prv_hi,
  input  wire logic [W-1:0]    prv_lo,
  input  wire logic [W-1:0]    prv_m,
  output logic                 rdy,
  input  wire logic            nxt_rdy,
  output logic                 vld_r,
  output umdu_pkg::tag_t       tag_r,
  output logic [W-1:0]         hi_r,
  output logic [W-1:0]         lo_r,
  output logic [W-1:0]         m_r
);

  logic [W:0]   mul_sum;
  logic [W:0]   div_sh;
  logic [W+1:0] div_diff;
  logic         div_ge;
  logic [W-1:0] hi_nxt;
  logic [W-1:0] lo_nxt;

  // Take a new word when empty or when the word held moves on
  assign rdy = !vld_r || nxt_rdy;

  // Multiply step: add multiplicand on a set multiplier bit, shift right
  assign mul_sum = {1'b0, prv_hi} + (prv_lo[0] ? {1'b0, prv_m} : '0);

  // Divide step: shift in next dividend bit, trial subtract the divisor
  assign div_sh   = {prv_hi, prv_lo[W-1]};
  assign div_diff = {1'b0, div_sh} - {2'b00, prv_m};
  assign div_ge   = !div_diff[W+1];

  always_comb begin
    if (prv_tag.op == umdu_pkg::OP_MUL) begin
      hi_nxt = mul_sum[W:1];
      lo_nxt = {mul_sum[0], prv_lo[W-1:1]};
    end else begin
      hi_nxt = div_ge ? div_diff[W-1:0] : div_sh[W-1:0];
      lo_nxt = {prv_lo[W-2:0], div_ge};
    end
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy) begin
      vld_r <= prv_vld;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (rdy && prv_vld) begin
      tag_r <= prv_tag;
      hi_r  <= hi_nxt;
      lo_r  <= lo_nxt;
      m_r   <= prv_m;
    end
  end

endmodule

`default_nettype wire
